FILE: hdl/rpe_pkg.sv
// shared types and constants for the run-length pixel encoder
package rpe_pkg;

	localparam int unsigned PIXEL_W     = 8;
	localparam int unsigned COLOR_W     = 3;
	localparam int unsigned COUNT_W     = 5;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	localparam logic [COUNT_W-1:0] SHORT_MAX = 5'd31;
	localparam logic [BYTE_W-1:0]  EXTRA_MAX = 8'd254;
	localparam logic [BYTE_W-1:0]  EXT_FULL  = 8'd255;

	// output bytes caused by one pixel, at most two
	typedef struct packed {
		logic                two;
		logic [BYTE_W-1:0]   byte0;
		logic                flast0;
		logic [BYTE_W-1:0]   byte1;
		logic                flast1;
	} rpe_entry_t;

endpackage

FILE: hdl/rle_pixel_encoder_top.sv
// top level of the run-length pixel encoder
//
//  channel  | dir | tdata             | tuser         | tlast
//  s_axis   | in  | [7:0] pixel       | -             | frame_end
//  m_axis   | out | [7:0] code_byte   | [0] item_last | frame_last
//
// one pixel per cycle is accepted while the four-entry queue has room
// a pixel yields zero, one or two bytes; the sender puts out one byte per cycle
// while m_axis is not stalled, so the two bytes of one pixel go out one by one
// run compare and increment are combinational, the queue write in the same cycle
// reset clears the run state, the queue pointers and the output valid
// a stalled m_axis fills the queue, then s_axis_tready drops
module rle_pixel_encoder_top import rpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] code_byte
	output logic        m_axis_tuser,   // [0] item_last
	output logic        m_axis_tlast
);

	rpe_entry_t wr_entry;
	rpe_entry_t rd_entry;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;
	logic       pix_valid;

	// request taken whenever the queue is not full
	assign s_axis_tready = !full;
	assign pix_valid     = s_axis_tvalid && !full;

	rpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pixel     (s_axis_tdata),
		.frame_end (s_axis_tlast),
		.push      (push),
		.entry     (wr_entry)
	);

	rpe_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (empty),
		.full     (full)
	);

	rpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_entry   (rd_entry),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.code_byte  (m_axis_tdata),
		.item_last  (m_axis_tuser),
		.frame_last (m_axis_tlast)
	);

endmodule

FILE: hdl/rpe_front.sv
// run tracker: accepts pixels, updates run state, queues the bytes each pixel causes
module rpe_front import rpe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	input  logic [PIXEL_W-1:0]  pixel,
	input  logic                frame_end,
	output logic                push,
	output rpe_entry_t          entry
);

	logic               active_q;
	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] short_q;
	logic               long_q;
	logic [BYTE_W-1:0]  extra_q;

	logic               active_n;
	logic [COLOR_W-1:0] color_n;
	logic [COUNT_W-1:0] short_n;
	logic               long_n;
	logic [BYTE_W-1:0]  extra_n;

	logic [COLOR_W-1:0] color;
	logic               pre_valid;
	logic [BYTE_W-1:0]  pre_byte;
	logic [BYTE_W-1:0]  close_byte;
	logic [COUNT_W-1:0] short_inc;

	assign color     = pixel[PIXEL_W-1 -: COLOR_W];
	assign short_inc = short_q + COUNT_W'(1);

	always_comb begin
		active_n  = active_q;
		color_n   = color_q;
		short_n   = short_q;
		long_n    = long_q;
		extra_n   = extra_q;
		pre_valid = 1'b0;
		pre_byte  = '0;
		if (active_q && color == color_q) begin
			if (!long_q) begin
				short_n = short_inc;
				if (short_inc == SHORT_MAX) begin
					// run reached 32: header goes out now
					pre_valid = 1'b1;
					pre_byte  = {color_q, SHORT_MAX};
					long_n    = 1'b1;
					extra_n   = '0;
				end
			end else if (extra_q >= EXTRA_MAX) begin
				pre_valid = 1'b1;
				pre_byte  = EXT_FULL;
				extra_n   = '0;
			end else begin
				extra_n = extra_q + BYTE_W'(1);
			end
		end else begin
			// color change closes the open run
			if (active_q) begin
				pre_valid = 1'b1;
				pre_byte  = long_q ? extra_q : {color_q, short_q};
			end
			active_n = 1'b1;
			color_n  = color;
			short_n  = '0;
			long_n   = 1'b0;
			extra_n  = '0;
		end

		close_byte = long_n ? extra_n : {color_n, short_n};

		entry.two    = pre_valid && frame_end;
		entry.byte0  = pre_valid ? pre_byte : close_byte;
		entry.flast0 = !pre_valid;
		entry.byte1  = close_byte;
		entry.flast1 = 1'b1;
		push         = pix_valid && (pre_valid || frame_end);

		if (frame_end) begin
			active_n = 1'b0;
			long_n   = 1'b0;
			short_n  = '0;
			extra_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			color_q  <= '0;
			short_q  <= '0;
			long_q   <= 1'b0;
			extra_q  <= '0;
		end else if (pix_valid) begin
			active_q <= active_n;
			color_q  <= color_n;
			short_q  <= short_n;
			long_q   <= long_n;
			extra_q  <= extra_n;
		end
	end

endmodule

FILE: hdl/rpe_fifo.sv
// short queue of byte groups between the run tracker and the byte sender
module rpe_fifo import rpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rpe_entry_t  wr_entry,
	input  logic        pop,
	output rpe_entry_t  rd_entry,
	output logic        empty,
	output logic        full
);

	rpe_entry_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/rpe_back.sv
// byte sender: splits queued groups into single bytes behind an output register
module rpe_back import rpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rpe_entry_t         rd_entry,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  code_byte,
	output logic               item_last,
	output logic               frame_last
);

	logic              valid_q;
	logic              phase_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ilast_q;
	logic              flast_q;
	logic              load;

	assign load       = !empty && (!valid_q || out_ready);
	assign pop        = load && (!rd_entry.two || phase_q);
	assign out_valid  = valid_q;
	assign code_byte  = byte_q;
	assign item_last  = ilast_q;
	assign frame_last = flast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= rd_entry.two && !phase_q;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= phase_q ? rd_entry.byte1 : rd_entry.byte0;
			flast_q <= phase_q ? rd_entry.flast1 : rd_entry.flast0;
			ilast_q <= phase_q || !rd_entry.two;
		end
	end

endmodule

FILE: verif/rle_pixel_encoder_top_tb.sv
// self-checking testbench for the run-length pixel encoder top level
module rle_pixel_encoder_top_tb import rpe_pkg::*; ();

	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 16;

	// one expected output byte with its flags
	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              item_last;
		logic              frame_last;
	} code_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] pixel
	logic        s_axis_tlast = 1'b0;  // frame_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [7:0] code_byte
	logic        m_axis_tuser;         // [0] item_last
	logic        m_axis_tlast;         // frame_last

	// predicted encoder state
	logic               pred_open = 1'b0;
	logic [COLOR_W-1:0] pred_color = '0;
	logic [COUNT_W-1:0] pred_short = '0;
	logic               pred_long = 1'b0;
	logic [BYTE_W-1:0]  pred_extra = '0;

	code_t pending_codes[$];
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;
	int    error_count = 0;
	int    cycle_count = 0;

	rle_pixel_encoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver back-pressure, rate set per phase
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// final byte of the open run, then no run stays open
	function automatic code_t close_open_run(logic frame_last);
		code_t c;
		c.item_last  = 1'b0;
		c.frame_last = frame_last;
		// a run past 31 ends with its remainder byte, a short run with color and count
		if (pred_long)
			c.code_byte = pred_extra;
		else
			c.code_byte = {pred_color, pred_short};
		pred_open  = 1'b0;
		pred_long  = 1'b0;
		pred_short = '0;
		pred_extra = '0;
		return c;
	endfunction

	// advance the predicted state by one pixel and queue the bytes it causes
	function automatic void encode_pixel(logic [7:0] pixel, logic frame_end);
		code_t              outs[$];
		code_t              c;
		logic [COLOR_W-1:0] color;
		color = pixel[7:5];
		c.item_last  = 1'b0;
		c.frame_last = 1'b0;
		if (pred_open && color == pred_color) begin
			if (!pred_long) begin
				pred_short = pred_short + 1'b1;
				// run reached 32: header goes out now
				if (pred_short == SHORT_MAX) begin
					c.code_byte = {pred_color, SHORT_MAX};
					outs.push_back(c);
					pred_long  = 1'b1;
					pred_extra = '0;
				end
			end else if (pred_extra == EXTRA_MAX) begin
				// remainder full: one 255 byte, remainder restarts
				c.code_byte = EXT_FULL;
				outs.push_back(c);
				pred_extra = '0;
			end else begin
				pred_extra = pred_extra + 1'b1;
			end
		end else begin
			// color change closes the old run first
			if (pred_open)
				outs.push_back(close_open_run(1'b0));
			pred_open  = 1'b1;
			pred_color = color;
			pred_short = '0;
			pred_long  = 1'b0;
			pred_extra = '0;
		end
		if (frame_end)
			outs.push_back(close_open_run(1'b1));
		if (outs.size() > 0)
			outs[outs.size()-1].item_last = 1'b1;
		foreach (outs[i])
			pending_codes.push_back(outs[i]);
	endfunction

	// compare each accepted output byte with the oldest prediction
	always @(posedge clk) begin
		code_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_codes.size() == 0) begin
				$error("unexpected output byte %0d", m_axis_tdata);
				error_count = error_count + 1;
			end else begin
				want = pending_codes.pop_front();
				if (m_axis_tdata !== want.code_byte) begin
					$error("code_byte: expected %0d, got %0d", want.code_byte, m_axis_tdata);
					error_count = error_count + 1;
				end
				if (m_axis_tuser !== want.item_last) begin
					$error("item_last: expected %0d, got %0d", want.item_last, m_axis_tuser);
					error_count = error_count + 1;
				end
				if (m_axis_tlast !== want.frame_last) begin
					$error("frame_last: expected %0d, got %0d", want.frame_last,
						m_axis_tlast);
					error_count = error_count + 1;
				end
			end
		end
	end

	// one pixel request, with random idle cycles ahead of it
	task automatic send_pixel(logic [7:0] pixel, logic frame_end);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pixel;
		s_axis_tlast  <= frame_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		encode_pixel(pixel, frame_end);
	endtask

	// no request is offered while the outputs drain
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
	endtask

	// one-pixel frames at the pixel extremes
	task automatic test_pixel_extremes();
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h1F, 1'b1);
		send_pixel(8'hE0, 1'b1);
	endtask

	// every color in turn, then a frame end on a new color
	task automatic test_color_change();
		for (int c = 0; c < 8; c++)
			send_pixel({3'(c), 5'($urandom)}, 1'b0);
		repeat (3)
			send_pixel({3'd7, 5'($urandom)}, 1'b0);
		// old run closes and the new one-pixel run closes on the same request
		send_pixel({3'd2, 5'($urandom)}, 1'b1);
	endtask

	// frame end inside a run, then on the first pixel of a frame
	task automatic test_frame_end();
		send_pixel(8'h40, 1'b0);
		send_pixel(8'h5F, 1'b0);
		send_pixel(8'h41, 1'b1);
		send_pixel(8'h41, 1'b1);
	endtask

	// header with frame end on pixel 32, then a run long enough for two 255 bytes
	task automatic test_long_runs();
		for (int i = 1; i <= 32; i++)
			send_pixel({3'd5, 5'($urandom)}, i == 32);
		// 255 bytes land on pixels 287 and 542; the last also flushes the remainder
		for (int i = 1; i <= 542; i++)
			send_pixel({3'd3, 5'($urandom)}, i == 542);
	endtask

	// mostly same-color runs of random length, some noise pixels
	task automatic test_random_runs(int n_items);
		int                 sent;
		int                 len;
		int                 pick;
		logic [COLOR_W-1:0] color;
		logic               end_frame;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 20) begin
				send_pixel(8'($urandom), $urandom_range(9) == 0);
				sent++;
			end else begin
				color = 3'($urandom);
				pick  = $urandom_range(99);
				if (pick < 80)
					len = $urandom_range(8, 1);
				else if (pick < 96)
					len = $urandom_range(40, 28);
				else
					len = $urandom_range(300, 250);
				end_frame = ($urandom_range(3) == 0);
				for (int i = 0; i < len; i++)
					send_pixel({color, 5'($urandom)}, end_frame && i == len - 1);
				sent += len;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender seldom idle, receiver often stalled
		send_idle_pct = 6;
		recv_idle_pct = 60;
		test_pixel_extremes();
		test_color_change();
		test_frame_end();
		test_long_runs();
		test_random_runs(90);
		wait_drained();

		// sender often idle, receiver seldom stalled
		send_idle_pct = 60;
		recv_idle_pct = 6;
		test_random_runs(90);
		wait_drained();

		// back-to-back requests on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_runs(90);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
